### rtl/idfl_pkg.sv
// Shared constants and types for the identifier free-list allocator.
package idfl_pkg;

  localparam int NUM_IDS = 4096;
  localparam int IDX_W   = $clog2(NUM_IDS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ID_W    = 16;

  localparam logic [ID_W-1:0] BASE_RESET = 16'd300;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_EXEC
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic accept;
    logic exec;
  } seq_ctrl_t;

endpackage

### rtl/idfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module idfl_ram #(
  parameter int DW = 8,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/idfl_seq.sv
// Two-step sequencer: lookup cycle at the request transfer, then the update cycle.
module idfl_seq
  import idfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output seq_ctrl_t ctl
);

  seq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (start) state_next = SEQ_EXEC;
      end
      SEQ_EXEC: begin
        state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    ctl.busy   = (state == SEQ_EXEC);
    ctl.exec   = (state == SEQ_EXEC);
    ctl.accept = (state == SEQ_IDLE) && start;
  end

endmodule

### rtl/id_free_list_allocator_core.sv
// Top level of the identifier free-list allocator: memories, shared adder, state.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// mode 0 allocates the identifier on top of the free stack; mode 1 releases
// release_id, which is pushed on top and reused first. Exactly one result
// follows each request: done is high for one cycle with granted_id and
// status; the receiver cannot hold it off.
// Timing: the transfer edge issues the memory reads, the next cycle decides
// and writes back, and the result shows in the cycle after that. busy is high
// for that one middle cycle, so no new request is taken before the last one has
// been decided and written back. One adder serves both the release offset
// (release_id - base_id) and the grant sum.
// base_id is written over the cfg channel (cfg_valid/cfg_ready), only while
// no request is in flight; cfg_ready is low while busy or while start is high.
// Reset: base_id returns to 300 and all identifiers are free, ascending.
// The RAMs are not cleared: a low-water mark of the free count tells which
// stack slots and bitmap bits were ever written, the rest read as reset
// values, so the block is ready right after reset with no clearing pass.
module id_free_list_allocator_core
  import idfl_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic            mode,
  input  logic [ID_W-1:0] release_id,
  output logic            done,
  output logic [ID_W-1:0] granted_id,
  output logic [1:0]      status,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [ID_W-1:0] cfg_data
);

  seq_ctrl_t ctl;

  logic [ID_W-1:0]  base_id;
  logic [CNT_W-1:0] fc;
  logic [CNT_W-1:0] lwm;

  logic             op_mode;
  logic [IDX_W-1:0] op_idx;
  logic             op_in_range;
  logic             stk_hit;
  logic             map_hit;

  logic [ID_W-1:0]  add_a, add_b, add_sum;
  logic             add_cin;

  logic [IDX_W-1:0] stk_rdata;
  logic [0:0]       map_rdata;
  logic             stk_we, map_we;
  logic [IDX_W-1:0] map_waddr;
  logic [IDX_W-1:0] alloc_idx;
  logic             alloc_ok, rel_ok;
  status_t          status_next;

  idfl_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctl   (ctl)
  );

  assign busy      = ctl.busy;
  // a base write never shares an edge with a request transfer
  assign cfg_ready = !ctl.busy && !start;

  // Shared adder: offset of the released id at transfer, grant sum in the update cycle.
  always_comb begin
    if (ctl.exec) begin
      add_a   = base_id;
      add_b   = {{(ID_W-IDX_W){1'b0}}, alloc_idx};
      add_cin = 1'b0;
    end else begin
      add_a   = release_id;
      add_b   = ~base_id;
      add_cin = 1'b1;
    end
    add_sum = add_a + add_b + {{(ID_W-1){1'b0}}, add_cin};
  end

  // Slots at or above the low-water mark were pushed since reset.
  assign alloc_idx = stk_hit ? stk_rdata : IDX_W'(CNT_W'(NUM_IDS) - fc);

  assign alloc_ok = !op_mode && (fc != '0);
  assign rel_ok   = op_mode && op_in_range && map_hit && map_rdata[0] &&
                    (fc < CNT_W'(NUM_IDS));

  assign stk_we    = ctl.exec && rel_ok;
  assign map_we    = ctl.exec && (alloc_ok || rel_ok);
  assign map_waddr = alloc_ok ? alloc_idx : op_idx;

  idfl_ram #(.DW(IDX_W), .AW(IDX_W)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (fc[IDX_W-1:0]),
    .wdata (op_idx),
    .re    (ctl.accept),
    .raddr (IDX_W'(fc - CNT_W'(1))),
    .rdata (stk_rdata)
  );

  idfl_ram #(.DW(1), .AW(IDX_W)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (alloc_ok),
    .re    (ctl.accept),
    .raddr (add_sum[IDX_W-1:0]),
    .rdata (map_rdata)
  );

  always_comb begin
    priority if (!op_mode) begin
      status_next = alloc_ok ? ST_GRANTED : ST_EXHAUSTED;
    end else begin
      status_next = rel_ok ? ST_RELEASED : ST_IGNORED;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_mode     <= mode;
      op_idx      <= add_sum[IDX_W-1:0];
      op_in_range <= (add_sum < ID_W'(NUM_IDS));
      stk_hit     <= (fc > lwm);
      // bitmap bits below NUM_IDS - lwm have been handed out at least once
      map_hit     <= (CNT_W'(add_sum[IDX_W-1:0]) < (CNT_W'(NUM_IDS) - lwm));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      granted_id <= alloc_ok ? add_sum : '0;
      status     <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      base_id <= BASE_RESET;
      fc      <= CNT_W'(NUM_IDS);
      lwm     <= CNT_W'(NUM_IDS);
    end else begin
      done <= ctl.exec;
      if (cfg_valid && cfg_ready) begin
        base_id <= cfg_data;
      end
      if (ctl.exec && alloc_ok) begin
        fc <= fc - CNT_W'(1);
        if (fc == lwm) lwm <= lwm - CNT_W'(1);
      end else if (ctl.exec && rel_ok) begin
        fc <= fc + CNT_W'(1);
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an update cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (fc <= CNT_W'(NUM_IDS)) && (lwm <= fc))
    else $error("free count or low-water mark out of order");

  a_grant_pops: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_GRANTED)) |-> (fc == $past(fc) - CNT_W'(1)))
    else $error("grant without a pop");

  a_release_pushes: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_RELEASED)) |-> (fc == $past(fc) + CNT_W'(1)))
    else $error("release without a push");

endmodule
